FILE: sv/idar_pkg.sv
// ----------------------------------------------------------------------------
// idar_pkg
// Opcodes, status codes and controller/datapath handshake types shared by
// the identifier allocator.
// ----------------------------------------------------------------------------
package idar_pkg;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_NOT_USED = 2'd2;

    localparam logic [7:0] REUSE_DELAY_RESET = 8'd10;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic rd_cur;
        logic rd_id;
        logic alloc_step;
        logic alloc_take;
        logic alloc_fail;
        logic id_fin;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic cur_end;
        logic step_lim;
        logic time_gt;
    } t_sts;

endpackage

FILE: sv/idar_if.sv
// ----------------------------------------------------------------------------
// idar_if
// Request and response channels of the identifier allocator.
// ----------------------------------------------------------------------------
interface idar_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  ident;
    logic [31:0] now;

    modport source (output valid, output opcode, output ident, output now, input ready);
    modport sink   (input valid, input opcode, input ident, input now, output ready);
endinterface

interface idar_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_ident;
    logic [1:0] status;
    logic       in_use;

    modport source (output valid, output result_ident, output status, output in_use,
                    input ready);
    modport sink   (input valid, input result_ident, input status, input in_use,
                    output ready);
endinterface

FILE: sv/idar_dp.sv
// ----------------------------------------------------------------------------
// idar_dp
// Datapath: link, ready time and allocated tables, free list head, walk
// registers, reuse delay register and result registers.
// ----------------------------------------------------------------------------
module idar_dp #(
    parameter int ID_COUNT = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_ident,
    input  logic [31:0]       i_now,
    input  idar_pkg::t_cmd    i_cmd,
    output idar_pkg::t_sts    o_sts,
    output logic [7:0]        o_result_ident,
    output logic [1:0]        o_status,
    output logic              o_in_use
);

    localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int LW = IW + 1;
    localparam int CW = (LW > 8) ? LW : 8;
    localparam logic [LW-1:0] END_MARK = LW'(ID_COUNT);

    logic [LW-1:0] link_mem  [ID_COUNT];
    logic [32:0]   time_mem  [ID_COUNT];
    logic          alloc_mem [ID_COUNT];

    logic [LW-1:0] r_free_head;
    logic [IW-1:0] r_clear_idx;
    logic [LW-1:0] r_cur;
    logic [LW-1:0] r_prev;
    logic [LW-1:0] r_steps;
    logic [1:0]    r_op;
    logic [7:0]    r_id;
    logic [31:0]   r_now;
    logic [7:0]    r_reuse_delay;
    logic [LW-1:0] r_link_q;
    logic [32:0]   r_time_q;
    logic          r_alloc_q;
    logic [7:0]    r_res_ident;
    logic [1:0]    r_res_status;
    logic          r_res_in_use;

    logic [CW-1:0] id_ext;
    logic [CW-1:0] cur_ext;
    logic [IW-1:0] id_idx;
    logic [IW-1:0] cur_idx;
    logic          id_in_range;
    logic          rel_ok;

    logic          link_we;
    logic [IW-1:0] link_addr;
    logic [LW-1:0] link_wdata;
    logic          time_we;
    logic [IW-1:0] time_addr;
    logic [32:0]   time_wdata;
    logic          alloc_we;
    logic [IW-1:0] alloc_addr;
    logic          alloc_wdata;

    assign id_ext      = CW'(r_id);
    assign cur_ext     = CW'(r_cur);
    assign id_idx      = id_ext[IW-1:0];
    assign cur_idx     = r_cur[IW-1:0];
    assign id_in_range = id_ext < CW'(ID_COUNT);
    assign rel_ok      = i_cmd.id_fin && (r_op == idar_pkg::OP_RELEASE)
                         && id_in_range && r_alloc_q;

    assign o_sts.clear_last = r_clear_idx == IW'(ID_COUNT - 1);
    assign o_sts.cur_end    = r_cur == END_MARK;
    assign o_sts.step_lim   = r_steps == LW'(ID_COUNT);
    assign o_sts.time_gt    = r_time_q > {1'b0, r_now};

    // table write port selection
    always_comb begin
        link_we    = 1'b0;
        link_addr  = r_clear_idx;
        link_wdata = {1'b0, r_clear_idx} + LW'(1);
        time_we    = 1'b0;
        time_addr  = r_clear_idx;
        time_wdata = '0;
        alloc_we   = 1'b0;
        alloc_addr = r_clear_idx;
        alloc_wdata = 1'b0;
        if (i_cmd.clear_wr) begin
            link_we  = 1'b1;
            time_we  = 1'b1;
            alloc_we = 1'b1;
        end else if (i_cmd.alloc_take) begin
            // unlink cur: a non-head predecessor gets cur's successor
            link_we     = r_prev != END_MARK;
            link_addr   = r_prev[IW-1:0];
            link_wdata  = r_link_q;
            alloc_we    = 1'b1;
            alloc_addr  = cur_idx;
            alloc_wdata = 1'b1;
        end else if (rel_ok) begin
            link_we     = 1'b1;
            link_addr   = id_idx;
            link_wdata  = r_free_head;
            time_we     = 1'b1;
            time_addr   = id_idx;
            time_wdata  = {1'b0, r_now} + 33'(r_reuse_delay);
            alloc_we    = 1'b1;
            alloc_addr  = id_idx;
            alloc_wdata = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_addr] <= link_wdata;
        end
        if (time_we) begin
            time_mem[time_addr] <= time_wdata;
        end
        if (alloc_we) begin
            alloc_mem[alloc_addr] <= alloc_wdata;
        end
        if (i_cmd.rd_cur) begin
            r_link_q <= link_mem[cur_idx];
            r_time_q <= time_mem[cur_idx];
        end
        if (i_cmd.rd_id) begin
            r_alloc_q <= alloc_mem[id_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head   <= '0;
            r_clear_idx   <= '0;
            r_reuse_delay <= idar_pkg::REUSE_DELAY_RESET;
        end else begin
            if (i_cfg_we) begin
                r_reuse_delay <= i_cfg_data;
            end
            if (i_cmd.clear_wr) begin
                r_clear_idx <= r_clear_idx + IW'(1);
            end
            if (i_cmd.alloc_take && (r_prev == END_MARK)) begin
                r_free_head <= r_link_q;
            end else if (rel_ok) begin
                r_free_head <= LW'(id_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= i_opcode;
            r_id         <= i_ident;
            r_now        <= i_now;
            r_cur        <= r_free_head;
            r_prev       <= END_MARK;
            r_steps      <= '0;
            r_res_ident  <= i_ident;
            r_res_status <= idar_pkg::ST_OK;
            r_res_in_use <= 1'b0;
        end
        if (i_cmd.alloc_step) begin
            r_prev  <= r_cur;
            r_cur   <= r_link_q;
            r_steps <= r_steps + LW'(1);
        end
        if (i_cmd.alloc_take) begin
            r_res_ident  <= cur_ext[7:0];
            r_res_status <= idar_pkg::ST_OK;
        end
        if (i_cmd.alloc_fail) begin
            r_res_ident  <= '0;
            r_res_status <= idar_pkg::ST_NONE;
        end
        if (i_cmd.id_fin) begin
            if (r_op == idar_pkg::OP_RELEASE) begin
                r_res_status <= rel_ok ? idar_pkg::ST_OK : idar_pkg::ST_NOT_USED;
            end else begin
                r_res_in_use <= id_in_range && r_alloc_q;
            end
        end
    end

    assign o_result_ident = r_res_ident;
    assign o_status       = r_res_status;
    assign o_in_use       = r_res_in_use;

`ifndef NO_ASSERTIONS
    a_take_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_take |-> (r_cur != END_MARK))
        else $error("allocation took the end marker");
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_step |-> (r_steps < LW'(ID_COUNT)))
        else $error("free list walk ran past the table size");
`endif

endmodule

FILE: sv/idar_ctrl.sv
// ----------------------------------------------------------------------------
// idar_ctrl
// Controller: clearing pass after reset, free list walk and lookup/release
// sequencing, result handshake.
// ----------------------------------------------------------------------------
module idar_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_opcode,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_out_ready,
    input  idar_pkg::t_sts i_sts,
    output idar_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ARD   = 3'd2;
    localparam logic [2:0] S_ACHK  = 3'd3;
    localparam logic [2:0] S_IDRD  = 3'd4;
    localparam logic [2:0] S_IDCHK = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_opcode)
                        idar_pkg::OP_ALLOC:   n_state = S_ARD;
                        idar_pkg::OP_RELEASE: n_state = S_IDRD;
                        idar_pkg::OP_LOOKUP:  n_state = S_IDRD;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_ARD: begin
                if (i_sts.cur_end || i_sts.step_lim) begin
                    o_cmd.alloc_fail = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state = S_ACHK;
                end
            end
            S_ACHK: begin
                // entry still cooling down: move on to its successor
                if (i_sts.time_gt) begin
                    o_cmd.alloc_step = 1'b1;
                    n_state = S_ARD;
                end else begin
                    o_cmd.alloc_take = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_IDRD: begin
                o_cmd.rd_id = 1'b1;
                n_state = S_IDCHK;
            end
            S_IDCHK: begin
                o_cmd.id_fin = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input taken while a result is pending");
    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACHK) |-> ($past(r_state) == S_ARD))
        else $error("ready time checked without a table read");
    a_id_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDCHK) |-> ($past(r_state) == S_IDRD))
        else $error("allocated flag used without a table read");
`endif

endmodule

FILE: sv/id_allocator_with_reuse_delay.sv
// ----------------------------------------------------------------------------
// id_allocator_with_reuse_delay
// Lookup and release: a table read and a check before the result; nop: result directly.
// Allocate: each free list entry visited is read from the one-port table and its ready
// time compared; the walk ends in a grant, or in a failure at the list end or limit.
// One item at a time: the next item is accepted once the result is taken.
// After reset a clearing pass over all ID_COUNT entries rebuilds the tables while
// no item is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module id_allocator_with_reuse_delay #(
    parameter int ID_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    idar_req_if.sink    i_req,
    idar_rsp_if.source  o_rsp
);

    idar_pkg::t_cmd cmd;
    idar_pkg::t_sts sts;

    idar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .i_opcode    (i_req.opcode),
        .o_ready     (i_req.ready),
        .o_valid     (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    idar_dp #(
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_req.opcode),
        .i_ident        (i_req.ident),
        .i_now          (i_req.now),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_ident (o_rsp.result_ident),
        .o_status       (o_rsp.status),
        .o_in_use       (o_rsp.in_use)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, release, look-up and no-op requests into the identifier
// allocator and checks each reply against a behavioural free-list model or
// a typed directed row. A directed table precedes random phases at several
// reuse delays with bursty requests, stalling replies and one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          ID_COUNT     = 256;
    localparam int unsigned LIST_END     = ID_COUNT;
    localparam int          LIMIT_CYCLES = 2_000_000;
    localparam int          NUM_PHASES   = 8;
    localparam int          NUM_DIRECTED = 19;

    typedef struct packed {
        logic [7:0] ident;
        logic [1:0] status;
        logic       in_use;
    } t_reply;

    typedef struct {
        bit     typed;
        t_reply want;
    } t_override;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  ident;
        logic [31:0] now;
        bit          typed;
        t_reply      want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [7:0] i_cfg_data;

    idar_req_if req_ch ();
    idar_rsp_if rsp_ch ();

    id_allocator_with_reuse_delay #(
        .ID_COUNT (ID_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // free-list model state
    int unsigned list_head;
    int unsigned link_tab [ID_COUNT];
    logic [32:0] free_at [ID_COUNT];
    bit          taken [ID_COUNT];
    logic [7:0]  delay_reg;

    t_reply    pending_replies [$];
    t_override typed_replies [$];
    int        error_count;
    int        reply_count;
    int        burst_left;
    logic [31:0] clock_now;

    t_dir_row dir_rows [0:NUM_DIRECTED-1] = '{
        '{idar_pkg::OP_LOOKUP,  8'h00, 32'h0000_0000, 1'b1,
          '{8'h00, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_RELEASE, 8'hFF, 32'h0000_0000, 1'b1,
          '{8'hFF, idar_pkg::ST_NOT_USED, 1'b0}},
        '{idar_pkg::OP_NOP,     8'hAA, 32'h0000_0000, 1'b1,
          '{8'hAA, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_ALLOC,   8'hFF, 32'h0000_0000, 1'b1,
          '{8'h00, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_ALLOC,   8'h00, 32'hFFFF_FFFF, 1'b1,
          '{8'h01, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_LOOKUP,  8'h00, 32'h0000_0000, 1'b1,
          '{8'h00, idar_pkg::ST_OK,       1'b1}},
        '{idar_pkg::OP_LOOKUP,  8'h01, 32'h0000_0000, 1'b1,
          '{8'h01, idar_pkg::ST_OK,       1'b1}},
        '{idar_pkg::OP_RELEASE, 8'h00, 32'hFFFF_FFFF, 1'b1,
          '{8'h00, idar_pkg::ST_OK,       1'b0}},
        // head entry not yet reusable, the walk has to skip it
        '{idar_pkg::OP_ALLOC,   8'h00, 32'hFFFF_FFFF, 1'b0,
          '{8'h00, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_RELEASE, 8'h00, 32'h0000_0005, 1'b1,
          '{8'h00, idar_pkg::ST_NOT_USED, 1'b0}},
        '{idar_pkg::OP_LOOKUP,  8'h00, 32'h0000_0005, 1'b1,
          '{8'h00, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_RELEASE, 8'h01, 32'h0000_0064, 1'b1,
          '{8'h01, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_ALLOC,   8'h00, 32'h0000_006D, 1'b0,
          '{8'h00, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_ALLOC,   8'h00, 32'h0000_006E, 1'b0,
          '{8'h00, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_NOP,     8'h55, 32'h5555_5555, 1'b1,
          '{8'h55, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_LOOKUP,  8'hFF, 32'hAAAA_AAAA, 1'b1,
          '{8'hFF, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_RELEASE, 8'h02, 32'h0000_0000, 1'b1,
          '{8'h02, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_ALLOC,   8'h00, 32'h0000_0000, 1'b0,
          '{8'h00, idar_pkg::ST_OK,       1'b0}},
        '{idar_pkg::OP_ALLOC,   8'h00, 32'h0000_000A, 1'b0,
          '{8'h00, idar_pkg::ST_OK,       1'b0}}
    };

    int unsigned phase_items [NUM_PHASES] = '{100, 300, 80, 80, 100, 80, 60, 50};
    int unsigned phase_alloc [NUM_PHASES] = '{50, 97, 40, 60, 90, 30, 55, 70};

    always #5 i_clk = ~i_clk;

    function automatic void clear_free_list();
        for (int i = 0; i < ID_COUNT; i++) begin
            link_tab[i] = i + 1;
            free_at[i]  = '0;
            taken[i]    = 1'b0;
        end
        list_head = 0;
        delay_reg = idar_pkg::REUSE_DELAY_RESET;
    endfunction

    function automatic t_reply compute_id_reply(logic [1:0] op, logic [7:0] id,
                                                logic [31:0] now);
        t_reply      r;
        int unsigned prev;
        int unsigned cur;
        int unsigned steps;
        r = '{ident: id, status: idar_pkg::ST_OK, in_use: 1'b0};
        case (op)
            idar_pkg::OP_ALLOC: begin
                prev  = LIST_END;
                cur   = list_head;
                steps = 0;
                while (cur < LIST_END && steps < ID_COUNT && free_at[cur] > {1'b0, now}) begin
                    prev = cur;
                    cur  = link_tab[cur];
                    steps++;
                end
                if (cur < LIST_END && steps < ID_COUNT) begin
                    if (prev == LIST_END)
                        list_head = link_tab[cur];
                    else
                        link_tab[prev] = link_tab[cur];
                    taken[cur] = 1'b1;
                    r.ident    = cur[7:0];
                end else begin
                    r.ident  = '0;
                    r.status = idar_pkg::ST_NONE;
                end
            end
            idar_pkg::OP_RELEASE: begin
                if (taken[id]) begin
                    taken[id]    = 1'b0;
                    free_at[id]  = {1'b0, now} + 33'(delay_reg);
                    link_tab[id] = list_head;
                    list_head    = id;
                end else begin
                    r.status = idar_pkg::ST_NOT_USED;
                end
            end
            idar_pkg::OP_LOOKUP: r.in_use = taken[id];
            default: ;
        endcase
        return r;
    endfunction

    // an identifier the model holds as allocated, if there is one
    function automatic logic [7:0] pick_taken_id();
        int unsigned start;
        start = $urandom_range(0, ID_COUNT - 1);
        for (int k = 0; k < ID_COUNT; k++) begin
            if (taken[(start + k) % ID_COUNT])
                return 8'((start + k) % ID_COUNT);
        end
        return 8'(start);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // request acceptance, configuration writes and reply checking
    always @(posedge i_clk) begin
        t_reply    got;
        t_reply    want;
        t_reply    modelled;
        t_override ov;
        if (i_rst_n) begin
            if (i_cfg_we)
                delay_reg = i_cfg_data;
            if (req_ch.valid && req_ch.ready) begin
                modelled = compute_id_reply(req_ch.opcode, req_ch.ident, req_ch.now);
                ov = typed_replies.pop_front();
                pending_replies.push_back(ov.typed ? ov.want : modelled);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = '{rsp_ch.result_ident, rsp_ch.status, rsp_ch.in_use};
                reply_count++;
                if (pending_replies.size() == 0) begin
                    flag_mismatch("unexpected reply, ident", got.ident, 0);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.ident !== want.ident)
                        flag_mismatch("result_ident", got.ident, want.ident);
                    if (got.status !== want.status)
                        flag_mismatch("status", got.status, want.status);
                    if (got.in_use !== want.in_use)
                        flag_mismatch("in_use", got.in_use, want.in_use);
                end
            end
        end
    end

    // reply side: always, random or patterned ready, plus one long hold-off
    initial begin
        int unsigned mode;
        int unsigned tick;
        int unsigned hold_left;
        bit          hold_done;
        rsp_ch.ready = 1'b0;
        mode      = 0;
        tick      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (tick % 50 == 0)
                mode = $urandom_range(0, 2);
            if (!hold_done && reply_count >= 120) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
                    default: rsp_ch.ready <= (tick % 5 >= 2);
                endcase
            end
        end
    end

    task automatic pause_requests(int unsigned n);
        req_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic offer_item(logic [1:0] op, logic [7:0] id, logic [31:0] now,
                              bit typed, t_reply want);
        typed_replies.push_back('{typed, want});
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.ident  <= id;
        req_ch.now    <= now;
        do @(posedge i_clk); while (!req_ch.ready);
        burst_left--;
        if (burst_left <= 0) begin
            pause_requests($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 16);
        end
    endtask

    task automatic drain_replies();
        pause_requests(1);
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reuse_delay(logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(int unsigned n_items, int unsigned alloc_pct);
        logic [1:0]  op;
        logic [7:0]  id;
        logic [31:0] now;
        int unsigned k;
        for (int i = 0; i < n_items; i++) begin
            id = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < alloc_pct) begin
                op = idar_pkg::OP_ALLOC;
            end else begin
                k = $urandom_range(0, 99);
                if (k < 50) begin
                    op = idar_pkg::OP_RELEASE;
                    id = pick_taken_id();
                end else if (k < 62) begin
                    op = idar_pkg::OP_RELEASE;
                end else if (k < 92) begin
                    op = idar_pkg::OP_LOOKUP;
                    if ($urandom_range(0, 1) == 1)
                        id = pick_taken_id();
                end else begin
                    op = idar_pkg::OP_NOP;
                end
            end
            clock_now += $urandom_range(0, 3);
            if ($urandom_range(0, 49) == 0)
                clock_now += $urandom_range(0, 600);
            now = ($urandom_range(0, 19) == 0) ? $urandom : clock_now;
            offer_item(op, id, now, 1'b0, '0);
        end
    endtask

    initial begin
        logic [7:0] phase_delay [NUM_PHASES];
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = idar_pkg::OP_NOP;
        req_ch.ident = '0;
        req_ch.now   = '0;
        error_count  = 0;
        reply_count  = 0;
        burst_left   = 1;
        clock_now    = '0;
        phase_delay  = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd255,
                         8'd128, 8'($urandom_range(2, 254)), 8'd0};
        clear_free_list();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table runs at the reset value of the reuse delay
        for (int i = 0; i < NUM_DIRECTED; i++)
            offer_item(dir_rows[i].op, dir_rows[i].ident, dir_rows[i].now,
                       dir_rows[i].typed, dir_rows[i].want);
        drain_replies();

        clock_now = 32'd200;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reuse_delay(phase_delay[p]);
            // one phase runs close to the top of the time range
            if (p == 4)
                clock_now = 32'hFFFF_FE00;
            run_phase(phase_items[p], phase_alloc[p]);
            drain_replies();
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_replies.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("timeout at %0t", $time);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
sv/idar_pkg.sv
sv/idar_if.sv
sv/idar_dp.sv
sv/idar_ctrl.sv
sv/id_allocator_with_reuse_delay.sv
tb/testbench.sv
